[design/assert_macros.svh]
// Assertion macros shared by the design modules.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ALB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition implies a property in the following cycle.
`define ALB_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[design/alb_pkg.sv]
// Shared types and constants of the activity LED brightness controller.
// Used by alb_core and by the top level; depends on nothing.
package alb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_LEVEL_MIN   = 3'd0;
    localparam logic [2:0] REG_LEVEL_MAX   = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd2;
    localparam logic [2:0] REG_RAMP_PERIOD = 3'd3;
    localparam logic [2:0] REG_OFF_DELAY   = 3'd4;
    localparam logic [2:0] REG_POLL_PERIOD = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_LEVEL_MIN   = 8'd10;
    localparam logic [7:0]  RST_LEVEL_MAX   = 8'd100;
    localparam logic [7:0]  RST_RAMP_STEP   = 8'd5;
    localparam logic [15:0] RST_RAMP_PERIOD = 16'd20;
    localparam logic [15:0] RST_OFF_DELAY   = 16'd5000;
    localparam logic [15:0] RST_POLL_PERIOD = 16'd50;

    // Request types and the caps lock position in the indicator bits.
    localparam logic REQ_TICK      = 1'b0;
    localparam logic REQ_INDICATOR = 1'b1;
    localparam int   CAPS_BIT      = 1;

    typedef struct packed {
        logic [7:0]  level_min;
        logic [7:0]  level_max;
        logic [7:0]  ramp_step;
        logic [15:0] ramp_period;
        logic [15:0] off_delay;
        logic [15:0] poll_period;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic       moving;
        logic [7:0] ambient_level;
        logic [7:0] indicators;
    } t_item;

    typedef struct packed {
        logic [7:0] led_level;
        logic       level_written;
        logic [7:0] last_lit_level;
    } t_result;

endpackage

[design/alb_core.sv]
// Brightness state and its per-item update: timers, caps ramp and activity polling.
// Depends on alb_pkg for the item, result and configuration types.
module alb_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  alb_pkg::t_item   i_item,
    input  alb_pkg::t_cfg    i_cfg,
    output alb_pkg::t_result o_res
);
    import alb_pkg::*;

    typedef struct packed {
        logic        caps_mode;
        logic        prev_moving;
        logic        ramp_rising;
        logic [7:0]  ramp_level;
        logic [7:0]  prev_ambient;
        logic [7:0]  current_level;
        logic [7:0]  lit_level;
        logic [15:0] ramp_count;
        logic [15:0] poll_count;
        logic [15:0] off_count;
        logic        off_armed;
        logic        ramp_armed;
    } t_state;

    t_state r_st;
    t_state n_st;
    logic   n_wrote;

    // Raises a level to the configured minimum.
    function automatic logic [7:0] floor_min(input logic [7:0] v, input logic [7:0] lo);
        return (v < lo) ? lo : v;
    endfunction

    // Next state for the item in the input register; later writes override earlier ones.
    always_comb begin
        logic       nc;
        logic [8:0] sum;
        logic [7:0] v;
        logic [7:0] lvl;
        n_st    = r_st;
        n_wrote = 1'b0;
        nc      = i_item.indicators[CAPS_BIT];
        sum     = 9'd0;
        v       = 8'd0;
        lvl     = 8'd0;
        if (i_item.req_type == REQ_INDICATOR) begin
            if (nc != r_st.caps_mode) begin
                n_st.caps_mode = nc;
                if (nc) begin
                    n_st.ramp_level  = i_cfg.level_min;
                    n_st.ramp_rising = 1'b1;
                    n_st.ramp_armed  = 1'b1;
                    n_st.ramp_count  = 16'd0;
                end else begin
                    n_st.ramp_armed    = 1'b0;
                    n_st.current_level = 8'd0;
                    n_wrote            = 1'b1;
                    if (i_item.moving) begin
                        lvl = floor_min(i_item.ambient_level, i_cfg.level_min);
                        n_st.current_level = lvl;
                        if (lvl != 8'd0) begin
                            n_st.lit_level = lvl;
                        end
                        n_st.off_armed = 1'b0;
                    end else begin
                        n_st.off_armed = 1'b1;
                        n_st.off_count = i_cfg.off_delay;
                    end
                end
            end
        end else begin
            // Auto-off timer.
            if (r_st.off_armed) begin
                if (r_st.off_count <= 16'd1) begin
                    n_st.off_count = 16'd0;
                    n_st.off_armed = 1'b0;
                    if (!r_st.caps_mode && !i_item.moving) begin
                        n_st.current_level = 8'd0;
                        n_wrote            = 1'b1;
                    end
                end else begin
                    n_st.off_count = r_st.off_count - 16'd1;
                end
            end
            // Ramp timer: show the level, then step it with saturation and reversal.
            if (r_st.ramp_armed) begin
                if (r_st.ramp_count <= 16'd1) begin
                    n_st.ramp_count = 16'd0;
                    n_st.ramp_armed = 1'b0;
                    if (r_st.caps_mode) begin
                        n_st.current_level = r_st.ramp_level;
                        if (r_st.ramp_level != 8'd0) begin
                            n_st.lit_level = r_st.ramp_level;
                        end
                        n_wrote = 1'b1;
                        if (r_st.ramp_rising) begin
                            sum = {1'b0, r_st.ramp_level} + {1'b0, i_cfg.ramp_step};
                            v   = sum[8] ? 8'hFF : sum[7:0];
                            if (v >= i_cfg.level_max) begin
                                v                = i_cfg.level_max;
                                n_st.ramp_rising = 1'b0;
                            end
                        end else begin
                            v = (r_st.ramp_level >= i_cfg.ramp_step)
                                ? (r_st.ramp_level - i_cfg.ramp_step) : 8'd0;
                            if (v <= i_cfg.level_min) begin
                                v                = i_cfg.level_min;
                                n_st.ramp_rising = 1'b1;
                            end
                        end
                        n_st.ramp_level = v;
                        n_st.ramp_armed = 1'b1;
                        n_st.ramp_count = i_cfg.ramp_period;
                    end
                end else begin
                    n_st.ramp_count = r_st.ramp_count - 16'd1;
                end
            end
            // Poll timer: activity start, activity end and ambient changes.
            if (r_st.poll_count <= 16'd1) begin
                if (!r_st.caps_mode) begin
                    if (i_item.moving && !r_st.prev_moving) begin
                        lvl = (i_item.ambient_level != 8'd0)
                            ? floor_min(i_item.ambient_level, i_cfg.level_min)
                            : i_cfg.level_max;
                        n_st.current_level = lvl;
                        if (lvl != 8'd0) begin
                            n_st.lit_level = lvl;
                        end
                        n_wrote        = 1'b1;
                        n_st.off_armed = 1'b0;
                    end else if (!i_item.moving && r_st.prev_moving) begin
                        n_st.off_armed = 1'b1;
                        n_st.off_count = i_cfg.off_delay;
                    end
                    if (i_item.ambient_level != r_st.prev_ambient) begin
                        n_st.prev_ambient = i_item.ambient_level;
                        if (i_item.ambient_level != 8'd0) begin
                            lvl = floor_min(i_item.ambient_level, i_cfg.level_min);
                            n_st.current_level = lvl;
                            n_st.lit_level     = lvl;
                            n_wrote            = 1'b1;
                            n_st.off_armed     = 1'b1;
                            n_st.off_count     = i_cfg.off_delay;
                        end
                    end
                end
                n_st.prev_moving = i_item.moving;
                n_st.poll_count  = i_cfg.poll_period;
            end else begin
                n_st.poll_count = r_st.poll_count - 16'd1;
            end
        end
    end

    // State register, updated once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.caps_mode     <= 1'b0;
            r_st.prev_moving   <= 1'b0;
            r_st.ramp_rising   <= 1'b1;
            r_st.ramp_level    <= RST_LEVEL_MIN;
            r_st.prev_ambient  <= 8'd0;
            r_st.current_level <= 8'd0;
            r_st.lit_level     <= RST_LEVEL_MIN;
            r_st.ramp_count    <= 16'd0;
            r_st.poll_count    <= 16'd0;
            r_st.off_count     <= 16'd0;
            r_st.off_armed     <= 1'b0;
            r_st.ramp_armed    <= 1'b0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_res.led_level      = n_st.current_level;
    assign o_res.level_written  = n_wrote;
    assign o_res.last_lit_level = n_st.lit_level;

endmodule

[design/activity_led_brightness_controller.sv]
// Usage notes for the activity LED brightness controller.
// Input channel: i_in_valid with the item fields, o_in_stall back to the sender.
// An item is a 1 ms tick (req_type 0) or an indicator change (req_type 1).
// Output channel: o_out_valid with one result per item, i_out_stall from the sink.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr; indexes
// 0..5 are level_min, level_max, ramp_step, ramp_period, off_delay, poll_period.
// Write configuration only while no item is in flight.
// Each item passes the input register, then the result register, where its
// result is offered; a sink stall holds it in either register. Throughput:
// one item per cycle while the sink does not stall, set by the combinational
// state update between the two registers.
// When the sink stalls, the result register holds; the input register fills
// next, and only then does o_in_stall rise.
// Reset (synchronous, active low) restores the register defaults, darkens the
// LEDs, sets the last lit level to the default minimum and arms the first
// poll for the first tick.
module activity_led_brightness_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic        i_moving,
    input  logic [7:0]  i_ambient_level,
    input  logic [7:0]  i_indicators,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_led_level,
    output logic        o_level_written,
    output logic [7:0]  o_last_lit_level,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import alb_pkg::*;
`include "assert_macros.svh"

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    logic    w_out_free;
    logic    w_step;
    logic    w_full_hold;
    logic    w_lit_write;
    logic    w_lit_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_min   <= RST_LEVEL_MIN;
            r_cfg.level_max   <= RST_LEVEL_MAX;
            r_cfg.ramp_step   <= RST_RAMP_STEP;
            r_cfg.ramp_period <= RST_RAMP_PERIOD;
            r_cfg.off_delay   <= RST_OFF_DELAY;
            r_cfg.poll_period <= RST_POLL_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEVEL_MIN:   r_cfg.level_min   <= i_cfg_wdata[7:0];
                REG_LEVEL_MAX:   r_cfg.level_max   <= i_cfg_wdata[7:0];
                REG_RAMP_STEP:   r_cfg.ramp_step   <= i_cfg_wdata[7:0];
                REG_RAMP_PERIOD: r_cfg.ramp_period <= i_cfg_wdata;
                REG_OFF_DELAY:   r_cfg.off_delay   <= i_cfg_wdata;
                REG_POLL_PERIOD: r_cfg.poll_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: the item moves on when the result register is free.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_item_valid && w_out_free;
    assign o_in_stall = r_item_valid && !w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.req_type      <= i_req_type;
            r_item.moving        <= i_moving;
            r_item.ambient_level <= i_ambient_level;
            r_item.indicators    <= i_indicators;
        end
    end

    alb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_led_level      = r_out.led_level;
    assign o_level_written  = r_out.level_written;
    assign o_last_lit_level = r_out.last_lit_level;

    // Terms used by the checks below.
    assign w_full_hold = r_item_valid && r_out_valid && i_out_stall;
    assign w_lit_write = r_out_valid && r_out.level_written && (r_out.led_level != 8'd0);
    assign w_lit_ok    = (r_out.last_lit_level == r_out.led_level);

    // A stepped item always shows up in the result register on the next cycle.
    `ALB_ASSERT_NEXT(a_step_lands, w_step, r_out_valid, "stepped item was lost")
    // Input stalls only when both registers are full and the sink holds off.
    `ALB_ASSERT(a_stall_cause, !o_in_stall || w_full_hold, "stall without full pipeline")
    // A nonzero written level is also the latest lit level.
    `ALB_ASSERT(a_lit_tracks, !w_lit_write || w_lit_ok, "lit level does not follow write")

endmodule
